>>> src/nearest_neighbor_tour_length_core_defines.svh
// Assertion macros for the nearest-neighbor tour length core
`ifndef NEAREST_NEIGHBOR_TOUR_LENGTH_CORE_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_LENGTH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define NNTL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nntl: implication check failed");
`define NNTL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nntl: next-cycle check failed");
`else
`define NNTL_ASSERT_IMP(label, ante, cons)
`define NNTL_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> src/nntl_pkg.sv
// Shared constants, types and distance function for the tour length core
`default_nettype none
package nntl_pkg;

    localparam int MAX_CITIES = 16;
    localparam int COORD_BITS = 16;
    localparam int IN_COORD_W = 16;
    localparam int LEN_W      = 21;

    localparam int IDX_W     = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int CNT_W     = $clog2(MAX_CITIES + 1);
    localparam int DIST_W    = COORD_BITS + 1;
    localparam int WAIT_LAST = MAX_CITIES + 1;
    localparam int WAIT_W    = $clog2(WAIT_LAST + 1);
    localparam int RUN_BASE  = COORD_BITS + 1 + CNT_W;
    localparam int RUN_W     = (RUN_BASE > LEN_W) ? RUN_BASE : LEN_W + 1;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic                  found;
        logic [DIST_W-1:0]     leg_len;
        logic [IDX_W-1:0]      idx;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } cand_t;

    typedef struct packed {
        logic                  load;
        logic                  mark;
        logic                  clear;
        logic [CNT_W-1:0]      count;
        logic [IDX_W-1:0]      mark_idx;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [COORD_BITS-1:0] load_x;
        logic [COORD_BITS-1:0] load_y;
    } cell_ctrl_t;

    function automatic logic [DIST_W-1:0] leg_dist(
        input logic [COORD_BITS-1:0] ax,
        input logic [COORD_BITS-1:0] ay,
        input logic [COORD_BITS-1:0] bx,
        input logic [COORD_BITS-1:0] by
    );
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        dx = (ax > bx) ? (ax - bx) : (bx - ax);
        dy = (ay > by) ? (ay - by) : (by - ay);
        return {1'b0, dx} + {1'b0, dy};
    endfunction

endpackage
`default_nettype wire

>>> src/nntl_cell.sv
// One city cell: stores a city, its distance to the current city, and a min-search link stage
`default_nettype none
module nntl_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [nntl_pkg::IDX_W-1:0] cell_idx,
    input  wire nntl_pkg::cell_ctrl_t       ctrl,
    input  wire nntl_pkg::cand_t            link_in,
    output nntl_pkg::cand_t                 link_out
);
    import nntl_pkg::*;

    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic                  visited_reg, visited_next;
    logic [DIST_W-1:0]     dist_reg;
    cand_t                 link_reg, link_next;
    logic                  hit_load;
    logic                  active;
    logic                  take;

    assign hit_load = ctrl.load && (ctrl.count == CNT_W'(cell_idx));
    assign active   = (CNT_W'(cell_idx) < ctrl.count) && !visited_reg;
    assign take     = active && (!link_in.found || (dist_reg < link_in.leg_len));

    always_comb
    begin
        visited_next = visited_reg;
        if (ctrl.clear)
        begin
            visited_next = 1'b0;
        end
        else if (hit_load)
        begin
            visited_next = (cell_idx == '0);
        end
        else if (ctrl.mark && (ctrl.mark_idx == cell_idx))
        begin
            visited_next = 1'b1;
        end
    end

    always_comb
    begin
        link_next = link_in;
        if (take)
        begin
            link_next.found   = 1'b1;
            link_next.leg_len = dist_reg;
            link_next.idx     = cell_idx;
            link_next.x       = x_reg;
            link_next.y       = y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
        end
        else
        begin
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_load)
        begin
            x_reg <= ctrl.load_x;
            y_reg <= ctrl.load_y;
        end
        dist_reg <= leg_dist(ctrl.cur_x, ctrl.cur_y, x_reg, y_reg);
        link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule
`default_nettype wire

>>> src/nearest_neighbor_tour_length_core.sv
// Loading: cities are taken while in_stall is low; after the last city the block steps the tour
// through S_START, one S_WAIT round per remaining city and S_DONE, which issues the result once the output is free.
// One set at a time: in_stall stays high until the result is issued; each tour step waits for
// the min-search to ripple through the row of MAX_CITIES cells.
// Reset: asynchronous, clears count, flags, visited bits and control; city store is undefined.
`default_nettype none
`include "nearest_neighbor_tour_length_core_defines.svh"
module nearest_neighbor_tour_length_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [nntl_pkg::IN_COORD_W-1:0] coord_x,
    input  wire logic [nntl_pkg::IN_COORD_W-1:0] coord_y,
    input  wire logic                            last_city,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [nntl_pkg::LEN_W-1:0]           tour_length,
    output logic                                 overflow
);
    import nntl_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [COORD_BITS-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [RUN_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      steps_reg, steps_next;
    logic [WAIT_W-1:0]     wait_reg, wait_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic                  in_acc;
    logic                  out_free;
    logic [RUN_W-1:0]      len_total;
    cell_ctrl_t            ctrl;
    cand_t                 link [0:MAX_CITIES];

    assign in_stall  = (state_reg != S_LOAD);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign len_total = len_reg + RUN_W'(leg_dist(cur_x_reg, cur_y_reg, x0_reg, y0_reg));

    assign link[0] = '0;

    for (genvar i = 0; i < MAX_CITIES; i++)
    begin : g_cell
        nntl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .ctrl     (ctrl),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        len_next       = len_reg;
        steps_next     = steps_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;

        ctrl          = '0;
        ctrl.count    = count_reg;
        ctrl.cur_x    = cur_x_reg;
        ctrl.cur_y    = cur_y_reg;
        ctrl.load_x   = coord_x[COORD_BITS-1:0];
        ctrl.load_y   = coord_y[COORD_BITS-1:0];
        ctrl.mark_idx = link[MAX_CITIES].idx;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CNT_W'(MAX_CITIES))
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (count_reg == '0)
                        begin
                            x0_next = coord_x[COORD_BITS-1:0];
                            y0_next = coord_y[COORD_BITS-1:0];
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_city)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cur_x_next = x0_reg;
                cur_y_next = y0_reg;
                len_next   = '0;
                steps_next = count_reg - 1'b1;
                wait_next  = '0;
                state_next = (count_reg == CNT_W'(1)) ? S_DONE : S_WAIT;
            end
            S_WAIT:
            begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == WAIT_W'(WAIT_LAST))
                begin
                    ctrl.mark  = 1'b1;
                    len_next   = len_reg + RUN_W'(link[MAX_CITIES].leg_len);
                    cur_x_next = link[MAX_CITIES].x;
                    cur_y_next = link[MAX_CITIES].y;
                    steps_next = steps_reg - 1'b1;
                    wait_next  = '0;
                    if (steps_reg == CNT_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = (len_total > RUN_W'(LEN_MAX)) ?
                                     LEN_MAX : len_total[LEN_W-1:0];
                    out_ovf_next   = ovf_reg;
                    ctrl.clear     = 1'b1;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            len_reg       <= '0;
            steps_reg     <= '0;
            wait_reg      <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            len_reg       <= len_next;
            steps_reg     <= steps_next;
            wait_reg      <= wait_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        out_len_reg <= out_len_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign tour_length = out_len_reg;
    assign overflow    = out_ovf_reg;

    `NNTL_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_CITIES))
    `NNTL_ASSERT_IMP(a_step_finds_city, (state_reg == S_WAIT) && (wait_reg == WAIT_W'(WAIT_LAST)),
                     link[MAX_CITIES].found)
    `NNTL_ASSERT_NXT(a_done_clears, (state_reg == S_DONE) && out_free,
                     (count_reg == '0) && out_valid_reg && (state_reg == S_LOAD))

endmodule
`default_nettype wire

>>> tb/nearest_neighbor_tour_length_core_test.sv
// Self-checking testbench for the nearest-neighbor tour length core
`default_nettype none
module nearest_neighbor_tour_length_core_test;
    import nntl_pkg::*;

    localparam int RANDOM_CITIES = 1350;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 2 + (MAX_CITIES - 1) * (MAX_CITIES + 2) + 20;
    localparam int HOLD_CYCLES   = 500;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             ovf;
    } tour_t;

    typedef struct packed {
        logic [IN_COORD_W-1:0] x;
        logic [IN_COORD_W-1:0] y;
        logic                  last;
        logic                  typed;
        logic [LEN_W-1:0]      len;
        logic                  ovf;
    } city_row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam city_row_t DIRECTED [DIRECTED_ROWS] = '{
        // single city at the far corner
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 21'd0, 1'b0},
        // two cities at opposite corners
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 21'd262140, 1'b0},
        // equal distances, lowest index wins
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'h000A, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'h0000, 16'h000A, 1'b1, 1'b0, 21'd0, 1'b0},
        // one city too many, the extra one is dropped
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'hFFFF, 16'h0000, 1'b0, 1'b0, 21'd0, 1'b0},
        '{16'h0000, 16'hFFFF, 1'b1, 1'b1, 21'd0, 1'b1}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [IN_COORD_W-1:0] coord_x;
    logic [IN_COORD_W-1:0] coord_y;
    logic                  last_city;
    logic                  out_valid;
    logic                  out_stall;
    logic [LEN_W-1:0]      tour_length;
    logic                  overflow;

    logic [COORD_BITS-1:0] stored_x [MAX_CITIES];
    logic [COORD_BITS-1:0] stored_y [MAX_CITIES];
    int                    stored_count;
    logic                  cities_dropped;
    tour_t                 pending_tours [$];

    int send_idle_pct;
    int recv_stall_pct;
    int tours_checked;
    int mismatches;
    int cycle_count;
    int random_sent;

    nearest_neighbor_tour_length_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .last_city   (last_city),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tour_length (tour_length),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint manhattan(input int a, input int b);
        longint dx;
        longint dy;
        dx = longint'(stored_x[a]) - longint'(stored_x[b]);
        dy = longint'(stored_y[a]) - longint'(stored_y[b]);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return dx + dy;
    endfunction

    function automatic tour_t greedy_tour();
        logic [MAX_CITIES-1:0] seen;
        int                    here;
        int                    pick;
        int                    step;
        int                    j;
        longint                total;
        longint                best;
        longint                d;
        tour_t                 res;
        seen    = '0;
        seen[0] = 1'b1;
        here    = 0;
        total   = 0;
        for (step = 1; step < stored_count; step++)
        begin
            pick = -1;
            best = 0;
            for (j = 0; j < stored_count; j++)
            begin
                if (!seen[j])
                begin
                    d = manhattan(here, j);
                    if (pick < 0 || d < best)
                    begin
                        pick = j;
                        best = d;
                    end
                end
            end
            total      = total + best;
            here       = pick;
            seen[pick] = 1'b1;
        end
        total   = total + manhattan(here, 0);
        res.len = (total > longint'(LEN_MAX)) ? LEN_MAX : total[LEN_W-1:0];
        res.ovf = cities_dropped;
        return res;
    endfunction

    task automatic send_city(
        input logic [IN_COORD_W-1:0] x,
        input logic [IN_COORD_W-1:0] y,
        input logic                  last,
        input logic                  typed,
        input tour_t                 typed_tour
    );
        tour_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        coord_x   <= x;
        coord_y   <= y;
        last_city <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (stored_count < MAX_CITIES)
        begin
            stored_x[stored_count] = x[COORD_BITS-1:0];
            stored_y[stored_count] = y[COORD_BITS-1:0];
            stored_count++;
        end
        else
            cities_dropped = 1'b1;
        if (last)
        begin
            predicted = greedy_tour();
            pending_tours.push_back(typed ? typed_tour : predicted);
            stored_count   = 0;
            cities_dropped = 1'b0;
        end
        @(negedge clk);
    endtask

    function automatic logic [IN_COORD_W-1:0] pick_coord(input int style);
        case (style)
            0: return IN_COORD_W'($urandom_range(0, 65535));
            1: return IN_COORD_W'($urandom_range(0, 7));
            default:
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return IN_COORD_W'($urandom);
                endcase
        endcase
    endfunction

    task automatic send_random_set();
        int    n;
        int    i;
        int    style;
        int    size_roll;
        tour_t unused;
        unused    = '0;
        size_roll = $urandom_range(0, 99);
        if (size_roll < 65)
            n = $urandom_range(1, 6);
        else if (size_roll < 90)
            n = $urandom_range(7, MAX_CITIES);
        else
            n = $urandom_range(MAX_CITIES + 1, MAX_CITIES + 4);
        style = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
        begin
            send_city(pick_coord(style), pick_coord(style), i == n - 1, 1'b0, unused);
            if (i < MAX_CITIES)
                random_sent++;
        end
    endtask

    // receiver: random stall, plus one long hold-off to back the block up
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && tours_checked >= 6)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        tour_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tours.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: tour_length=%0d overflow=%0b",
                             tour_length, overflow);
            end
            else
            begin
                want = pending_tours.pop_front();
                if (tour_length !== want.len || overflow !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("tour %0d mismatch: expected len=%0d ovf=%0b, got len=%0d ovf=%0b",
                                 tours_checked, want.len, want.ovf, tour_length, overflow);
                end
            end
            tours_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int    row;
        tour_t typed_tour;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        coord_x        = '0;
        coord_y        = '0;
        last_city      = 1'b0;
        stored_count   = 0;
        cities_dropped = 1'b0;
        tours_checked  = 0;
        mismatches     = 0;
        cycle_count    = 0;
        random_sent    = 0;
        send_idle_pct  = 28;
        recv_stall_pct = 66;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            typed_tour.len = DIRECTED[row].len;
            typed_tour.ovf = DIRECTED[row].ovf;
            send_city(DIRECTED[row].x, DIRECTED[row].y, DIRECTED[row].last,
                      DIRECTED[row].typed, typed_tour);
        end

        while (random_sent < RANDOM_CITIES)
        begin
            if (random_sent >= 2 * RANDOM_CITIES / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (random_sent >= RANDOM_CITIES / 3)
            begin
                send_idle_pct  = 66;
                recv_stall_pct = 28;
            end
            send_random_set();
        end
        in_valid <= 1'b0;

        while (pending_tours.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_tours.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

>>> nearest_neighbor_tour_length_core.f
+incdir+src
src/nntl_pkg.sv
src/nntl_cell.sv
src/nearest_neighbor_tour_length_core.sv
tb/nearest_neighbor_tour_length_core_test.sv
